>>> sv/sxe_pkg.sv
// Shared types and constants for the Slater exchange evaluator.
// Fixed-point widths of the cube-root chain and the scaling tail live here.
// No dependencies.
package sxe_pkg;

   // Field widths and fixed-point formats.
   localparam int DENSITY_FRAC_BITS = 24;
   localparam int RHO_W             = 32;
   localparam int COEF_W            = 28;
   localparam int COEF_FRAC         = 24;
   localparam int ENERGY_W          = 48;
   localparam int POTENTIAL_W       = 32;

   // Cube-root radicand is rho scaled so that the root comes out in Q.24.
   localparam int ROOT_SHIFT = 3 * COEF_FRAC - DENSITY_FRAC_BITS;
   localparam int RAD_W      = RHO_W + ROOT_SHIFT;
   localparam int ROOT_STEPS = (RAD_W + 2) / 3;
   localparam int RAD_PAD_W  = 3 * ROOT_STEPS;
   localparam int ROOT_W     = ROOT_STEPS;
   localparam int SQ_W       = 2 * ROOT_W;
   localparam int REM_W      = 2 * ROOT_W + 2;
   localparam int TRY_W      = REM_W + 3;

   // Scaling tail widths.
   localparam int MUL_W   = RHO_W + ROOT_W;
   localparam int TERM_W  = MUL_W - DENSITY_FRAC_BITS;
   localparam int PPROD_W = COEF_W + ROOT_W;
   localparam int SUM_W   = TERM_W + 1;
   localparam int SPLIT_W = SUM_W / 2;
   localparam int EPART_W = COEF_W + SUM_W - SPLIT_W;
   localparam int EPROD_W = COEF_W + SUM_W;
   localparam int SAT_W   = 64;
   localparam int TAIL_STAGES = 4;

   // Total number of item slots between input and output.
   localparam int PIPE_DEPTH = ROOT_STEPS + TAIL_STAGES;
   localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENERGY_COEF    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POTENTIAL_COEF = 1'b1;

   // Reset coefficients, both negative, kept as magnitude and sign.
   localparam logic [COEF_W-1:0] ENERGY_COEF_RESET_MAG    = COEF_W'(15611619);
   localparam logic [COEF_W-1:0] POTENTIAL_COEF_RESET_MAG = COEF_W'(20815492);

   typedef struct packed {
      logic              mode;
      logic [RHO_W-1:0]  rho_a;
      logic [RHO_W-1:0]  rho_b;
   } req_payload_type;

   typedef struct packed {
      logic signed [ENERGY_W-1:0]    energy_density;
      logic signed [POTENTIAL_W-1:0] potential_a;
      logic signed [POTENTIAL_W-1:0] potential_b;
   } rsp_payload_type;

   // Coefficients as magnitude and sign, as the tail consumes them.
   typedef struct packed {
      logic [COEF_W-1:0] energy_mag;
      logic              energy_neg;
      logic [COEF_W-1:0] potential_mag;
      logic              potential_neg;
   } coef_set_type;

   // Partial cube root of one density.
   typedef struct packed {
      logic [RHO_W-1:0]  rho;
      logic [ROOT_W-1:0] root;
      logic [SQ_W-1:0]   square;
      logic [REM_W-1:0]  rem;
   } root_lane_type;

   typedef struct packed {
      root_lane_type a;
      root_lane_type b;
   } cell_data_type;

endpackage

>>> sv/slater_exchange_evaluator.sv
// Slater LDA exchange evaluator: a chain of cube-root cells followed by a scaling tail.
// Items pass through the cube-root cells and then the scaling tail.
// One item per cycle while rsp_stall is low; every cube-root cell finishes one root bit.
// Reset clears all stage valid bits and loads the default Slater coefficients.
// Depends on sxe_pkg, sxe_root_cell and sxe_scale.
module slater_exchange_evaluator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sxe_pkg::req_payload_type          req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sxe_pkg::rsp_payload_type          rsp_data,
   input  logic                              csr_write_enable,
   input  logic [sxe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic signed [sxe_pkg::COEF_W-1:0] csr_write_data
);
   import sxe_pkg::*;

   // Three radicand bits that the cell at a given position consumes.
   function automatic logic [2:0] root_digit(input logic [RHO_W-1:0] rho,
                                             input int step);
      logic [RAD_PAD_W-1:0] rad;
      rad = RAD_PAD_W'(rho) << ROOT_SHIFT;
      return rad[RAD_PAD_W-1-3*step -: 3];
   endfunction

   coef_set_type      coef_ff;
   coef_set_type      coef_in;
   logic [COEF_W-1:0] write_mag;
   logic              write_neg;

   // Coefficient registers hold magnitude and sign, split once at write time.
   always_comb begin
      write_neg = csr_write_data[COEF_W-1];
      write_mag = write_neg ? (COEF_W'(0) - COEF_W'(csr_write_data))
                            : COEF_W'(csr_write_data);
      coef_in   = coef_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENERGY_COEF: begin
               coef_in.energy_mag = write_mag;
               coef_in.energy_neg = write_neg;
            end
            CSR_POTENTIAL_COEF: begin
               coef_in.potential_mag = write_mag;
               coef_in.potential_neg = write_neg;
            end
            default: begin
               coef_in = coef_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.energy_mag    <= ENERGY_COEF_RESET_MAG;
         coef_ff.energy_neg    <= 1'b1;
         coef_ff.potential_mag <= POTENTIAL_COEF_RESET_MAG;
         coef_ff.potential_neg <= 1'b1;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Cell chain; position 0 is the input transfer.
   cell_data_type       stage_data [ROOT_STEPS+1];
   logic [ROOT_STEPS:0] stage_valid;
   logic [ROOT_STEPS:0] stage_ready;
   logic [2:0]          digit_a [ROOT_STEPS];
   logic [2:0]          digit_b [ROOT_STEPS];

   // Restricted mode feeds rho_a into both lanes.
   assign stage_valid[0] = req_valid;
   assign stage_data[0]  = {req_data.rho_a, ROOT_W'(0), SQ_W'(0), REM_W'(0),
                            req_data.mode ? req_data.rho_a : req_data.rho_b,
                            ROOT_W'(0), SQ_W'(0), REM_W'(0)};

   assign req_stall = !stage_ready[0];

   for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_cell
      assign digit_a[s] = root_digit(stage_data[s].a.rho, s);
      assign digit_b[s] = root_digit(stage_data[s].b.rho, s);

      sxe_root_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (stage_valid[s]),
         .in_data    (stage_data[s]),
         .digit_a    (digit_a[s]),
         .digit_b    (digit_b[s]),
         .next_ready (stage_ready[s+1]),
         .ready      (stage_ready[s]),
         .out_valid  (stage_valid[s+1]),
         .out_data   (stage_data[s+1])
      );
   end

   // Scaling tail ending in the result register.
   sxe_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[ROOT_STEPS]),
      .in_data   (stage_data[ROOT_STEPS]),
      .in_ready  (stage_ready[ROOT_STEPS]),
      .coef      (coef_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sv/sxe_root_cell.sv
// One cell of the digit-by-digit cube-root chain: one root bit for each spin.
// Depends on sxe_pkg.
module sxe_root_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  sxe_pkg::cell_data_type in_data,
   input  logic [2:0]            digit_a,
   input  logic [2:0]            digit_b,
   input  logic                  next_ready,
   output logic                  ready,
   output logic                  out_valid,
   output sxe_pkg::cell_data_type out_data
);
   import sxe_pkg::*;

   // Restoring cube-root step. With y the root so far, the next bit is one when
   // 8*rem + digit covers (2y+1)^3 - (2y)^3 = 12y^2 + 6y + 1. The square is
   // tracked incrementally so that no multiplier is needed.
   function automatic root_lane_type root_step(input root_lane_type lane,
                                               input logic [2:0] digit);
      root_lane_type    nxt;
      logic [TRY_W-1:0] trial;
      logic [TRY_W-1:0] delta;
      trial = {lane.rem, digit};
      delta = (TRY_W'(lane.square) << 3) + (TRY_W'(lane.square) << 2)
            + (TRY_W'(lane.root) << 2) + (TRY_W'(lane.root) << 1) + TRY_W'(1);
      nxt.rho = lane.rho;
      if (trial >= delta) begin
         nxt.rem    = REM_W'(trial - delta);
         nxt.root   = {lane.root[ROOT_W-2:0], 1'b1};
         nxt.square = (lane.square << 2) + (SQ_W'(lane.root) << 2) + SQ_W'(1);
      end else begin
         nxt.rem    = trial[REM_W-1:0];
         nxt.root   = {lane.root[ROOT_W-2:0], 1'b0};
         nxt.square = lane.square << 2;
      end
      return nxt;
   endfunction

   logic          valid_ff;
   logic          valid_in;
   cell_data_type data_ff;
   cell_data_type data_in;

   // The cell takes a new item when it is empty or its content moves on.
   always_comb begin
      ready     = !valid_ff || next_ready;
      valid_in  = ready ? in_valid : valid_ff;
      data_in.a = root_step(in_data.a, digit_a);
      data_in.b = root_step(in_data.b, digit_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> sv/sxe_scale.sv
// Scaling tail: four-thirds powers, coefficient products and saturation.
// Four registered stages, the last one is the result register. Depends on sxe_pkg.
module sxe_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  sxe_pkg::cell_data_type  in_data,
   output logic                    in_ready,
   input  sxe_pkg::coef_set_type   coef,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sxe_pkg::rsp_payload_type rsp_data
);
   import sxe_pkg::*;

   localparam logic [SAT_W-1:0] ENERGY_MAX =
      (SAT_W'(1) << (ENERGY_W - 1)) - SAT_W'(1);
   localparam logic [SAT_W-1:0] POTENTIAL_MAX =
      (SAT_W'(1) << (POTENTIAL_W - 1)) - SAT_W'(1);

   // Apply the sign to a magnitude and clamp it to the energy field.
   function automatic logic [ENERGY_W-1:0] sat_energy(input logic [SAT_W-1:0] mag,
                                                      input logic neg);
      logic [SAT_W-1:0] lim;
      lim = mag;
      if (!neg && mag > ENERGY_MAX) begin
         lim = ENERGY_MAX;
      end else if (neg && mag > ENERGY_MAX + SAT_W'(1)) begin
         lim = ENERGY_MAX + SAT_W'(1);
      end
      if (neg) begin
         lim = SAT_W'(0) - lim;
      end
      return lim[ENERGY_W-1:0];
   endfunction

   // Same for a potential field.
   function automatic logic [POTENTIAL_W-1:0] sat_potential(
         input logic [SAT_W-1:0] mag, input logic neg);
      logic [SAT_W-1:0] lim;
      lim = mag;
      if (!neg && mag > POTENTIAL_MAX) begin
         lim = POTENTIAL_MAX;
      end else if (neg && mag > POTENTIAL_MAX + SAT_W'(1)) begin
         lim = POTENTIAL_MAX + SAT_W'(1);
      end
      if (neg) begin
         lim = SAT_W'(0) - lim;
      end
      return lim[POTENTIAL_W-1:0];
   endfunction

   // Stage valids and per-stage readiness; a stage loads when it is empty
   // or its content moves on.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   // Stage 1: four-thirds power terms and potential products.
   logic [TERM_W-1:0]  t1_ta_ff, t1_tb_ff;
   logic [PPROD_W-1:0] t1_pa_ff, t1_pb_ff;
   logic [MUL_W-1:0]   prod_a, prod_b;
   // Stage 2: energy sum and saturated potentials.
   logic [SUM_W-1:0]       t2_sum_ff;
   logic [POTENTIAL_W-1:0] t2_pa_ff, t2_pb_ff;
   // Stage 3: energy partial products.
   logic [EPART_W-1:0]     t3_lo_ff, t3_hi_ff;
   logic [POTENTIAL_W-1:0] t3_pa_ff, t3_pb_ff;
   // Stage 4: result register.
   logic [EPROD_W-1:0] energy_full;
   rsp_payload_type    t4_ff;

   always_comb begin
      rdy4     = !v4_ff || !rsp_stall;
      rdy3     = !v3_ff || rdy4;
      rdy2     = !v2_ff || rdy3;
      rdy1     = !v1_ff || rdy2;
      in_ready = rdy1;
      v1_in    = rdy1 ? in_valid : v1_ff;
      v2_in    = rdy2 ? v1_ff : v2_ff;
      v3_in    = rdy3 ? v2_ff : v3_ff;
      v4_in    = rdy4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Density times its cube root, truncated back to Q.24.
   always_comb begin
      prod_a = MUL_W'(in_data.a.rho) * MUL_W'(in_data.a.root);
      prod_b = MUL_W'(in_data.b.rho) * MUL_W'(in_data.b.root);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         t1_ta_ff <= prod_a[MUL_W-1:DENSITY_FRAC_BITS];
         t1_tb_ff <= prod_b[MUL_W-1:DENSITY_FRAC_BITS];
         t1_pa_ff <= PPROD_W'(coef.potential_mag) * PPROD_W'(in_data.a.root);
         t1_pb_ff <= PPROD_W'(coef.potential_mag) * PPROD_W'(in_data.b.root);
      end
   end

   // Sum of terms; potentials truncate toward zero and then saturate.
   always_ff @(posedge clock) begin
      if (rdy2) begin
         t2_sum_ff <= SUM_W'(t1_ta_ff) + SUM_W'(t1_tb_ff);
         t2_pa_ff  <= sat_potential(SAT_W'(t1_pa_ff[PPROD_W-1:COEF_FRAC]),
                                    coef.potential_neg);
         t2_pb_ff  <= sat_potential(SAT_W'(t1_pb_ff[PPROD_W-1:COEF_FRAC]),
                                    coef.potential_neg);
      end
   end

   // The wide energy product is split into two narrower partial products.
   always_ff @(posedge clock) begin
      if (rdy3) begin
         t3_lo_ff <= EPART_W'(coef.energy_mag) * EPART_W'(t2_sum_ff[SPLIT_W-1:0]);
         t3_hi_ff <= EPART_W'(coef.energy_mag) * EPART_W'(t2_sum_ff[SUM_W-1:SPLIT_W]);
         t3_pa_ff <= t2_pa_ff;
         t3_pb_ff <= t2_pb_ff;
      end
   end

   // Recombine, drop the coefficient fraction and saturate the energy.
   assign energy_full = (EPROD_W'(t3_hi_ff) << SPLIT_W) + EPROD_W'(t3_lo_ff);

   always_ff @(posedge clock) begin
      if (rdy4) begin
         t4_ff.energy_density <= sat_energy(SAT_W'(energy_full[EPROD_W-1:COEF_FRAC]),
                                            coef.energy_neg);
         t4_ff.potential_a    <= t3_pa_ff;
         t4_ff.potential_b    <= t3_pb_ff;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = t4_ff;

endmodule

>>> sv/sxe_checker.sv
// Port-level checker for the Slater exchange evaluator, bound to the top level.
// Tracks items in flight from the transfers it sees. Depends on sxe_pkg.
module sxe_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input sxe_pkg::rsp_payload_type rsp_data
);
   import sxe_pkg::*;

   logic             in_xfer;
   logic             out_xfer;
   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;

   // Items accepted whose result has not yet been transferred.
   always_comb begin
      in_xfer  = req_valid && !req_stall;
      out_xfer = rsp_valid && !rsp_stall;
      occ_in   = occ_ff + OCC_W'(in_xfer) - OCC_W'(out_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // A waiting result holds its value until it is transferred.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The input is held back only when every slot is full and the output waits.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // No result without an item in flight, and never more items than slots.
   assert property (@(posedge clock) disable iff (reset)
      out_xfer |-> occ_ff != '0)
      else $error("result without a matching item");

   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(PIPE_DEPTH))
      else $error("more items in flight than pipeline slots");

endmodule

bind slater_exchange_evaluator sxe_checker u_checker (.*);
